[rtl/core/word_load_store_unit_defines.svh]
// ----------------------------------------------------------------------------
// word_load_store_unit_defines
// Assertion macros for the load/store unit.
// ----------------------------------------------------------------------------
`ifndef WORD_LOAD_STORE_UNIT_DEFINES_SVH
`define WORD_LOAD_STORE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WLS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/wlsu_pkg.sv]
// ----------------------------------------------------------------------------
// wlsu_pkg
// Types, constants and helpers for the word load/store unit.
// ----------------------------------------------------------------------------
package wlsu_pkg;

    localparam int unsigned MEM_WORDS_DEF = 16384;

    localparam logic [31:0] GPIO_SEL0 = 32'h2020_0000;
    localparam logic [31:0] GPIO_SEL1 = 32'h2020_0004;
    localparam logic [31:0] GPIO_SEL2 = 32'h2020_0008;
    localparam logic [31:0] GPIO_CLR  = 32'h2020_0028;
    localparam logic [31:0] GPIO_SET  = 32'h2020_001C;

    localparam logic [2:0] ST_SKIP  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_GSEL  = 3'd3;
    localparam logic [2:0] ST_PIN   = 3'd4;
    localparam logic [2:0] ST_OOB   = 3'd5;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [3:0]  cond_flags;
        logic [31:0] base_value;
        logic [31:0] offset_reg_value;
        logic [31:0] amount_reg_value;
        logic [31:0] store_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        dest_write;
        logic [31:0] dest_value;
        logic        base_write;
        logic [31:0] new_base;
        logic [31:0] eff_address;
    } t_out_item;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;    // classified outcome
        logic       two_words;
    } t_dp_status;

    // controller -> datapath
    typedef struct packed {
        logic decode;  // latch item, issue reads
        logic finish;  // reads valid, write / report
    } t_dp_cmd;

    function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
        logic n, z, cy, v;
        n = f[3]; z = f[2]; cy = f[1]; v = f[0];
        case (c)
            4'd0:    cond_pass = z;
            4'd1:    cond_pass = !z;
            4'd2:    cond_pass = cy;
            4'd3:    cond_pass = !cy;
            4'd4:    cond_pass = n;
            4'd5:    cond_pass = !n;
            4'd6:    cond_pass = v;
            4'd7:    cond_pass = !v;
            4'd8:    cond_pass = cy && !z;
            4'd9:    cond_pass = !cy || z;
            4'd10:   cond_pass = n == v;
            4'd11:   cond_pass = n != v;
            4'd12:   cond_pass = !z && (n == v);
            4'd13:   cond_pass = z || (n != v);
            4'd14:   cond_pass = 1'b1;
            default: cond_pass = 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] shift_val(input logic [31:0] x, input logic [1:0] ty,
                                              input logic [7:0] amt);
        logic [63:0] rr;
        shift_val = x;
        rr = {x, x} >> amt[4:0];
        if (amt != 8'd0) begin
            case (ty)
                SH_LSL:  shift_val = (amt >= 8'd32) ? 32'd0 : (x << amt[4:0]);
                SH_LSR:  shift_val = (amt >= 8'd32) ? 32'd0 : (x >> amt[4:0]);
                SH_ASR:  shift_val = (amt >= 8'd32) ? {32{x[31]}}
                                                    : 32'($signed(x) >>> amt[4:0]);
                default: shift_val = rr[31:0];
            endcase
        end
    endfunction

endpackage

[rtl/core/wlsu_datapath.sv]
// ----------------------------------------------------------------------------
// wlsu_datapath
// Address generation, classification, word memory and byte merge.
// ----------------------------------------------------------------------------
module wlsu_datapath #(
    parameter int unsigned MEM_WORDS = wlsu_pkg::MEM_WORDS_DEF
) (
    input  logic                 i_clk,
    input  wlsu_pkg::t_in_item   i_item,
    input  wlsu_pkg::t_dp_cmd    i_cmd,
    input  logic                 i_clr_en,
    input  logic [$clog2(MEM_WORDS)-1:0] i_clr_addr,
    output wlsu_pkg::t_dp_status o_status,
    output wlsu_pkg::t_out_item  o_result
);
    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam logic [33:0] LIMIT = 34'(MEM_WORDS) * 34'd4;

    logic [31:0] r_mem [MEM_WORDS];

    logic [31:0] n_off, n_addr, n_acc;
    logic        n_pass;
    logic [2:0]  n_kind;
    logic [7:0]  n_amt;

    logic [31:0] r_addr, r_sd;
    logic [1:0]  r_lane;
    logic        r_pre, r_load;
    logic [2:0]  r_kind;
    logic [AW-1:0] r_w0, r_w1;
    logic [31:0] r_d0, r_d1;
    logic        r_two;
    logic [AW-1:0] n_w0, n_w1;

    always_comb begin
        n_amt = i_item.instr_word[4] ? i_item.amount_reg_value[7:0]
                                     : {3'd0, i_item.instr_word[11:7]};
        n_off = i_item.instr_word[25]
              ? wlsu_pkg::shift_val(i_item.offset_reg_value, i_item.instr_word[6:5], n_amt)
              : {20'd0, i_item.instr_word[11:0]};
        n_addr = i_item.instr_word[23] ? i_item.base_value + n_off
                                       : i_item.base_value - n_off;
        n_acc = i_item.instr_word[24] ? n_addr : i_item.base_value;
        n_pass = wlsu_pkg::cond_pass(i_item.instr_word[31:28], i_item.cond_flags);
        // in-bounds accesses never pass the last word; the wrap only guards the index
        n_w0 = AW'(n_acc >> 2);
        n_w1 = (n_w0 == AW'(MEM_WORDS - 1)) ? '0 : n_w0 + AW'(1);
        if (!n_pass)
            n_kind = wlsu_pkg::ST_SKIP;
        else if (n_addr == wlsu_pkg::GPIO_SEL0 || n_addr == wlsu_pkg::GPIO_SEL1 ||
                 n_addr == wlsu_pkg::GPIO_SEL2)
            n_kind = wlsu_pkg::ST_GSEL;
        else if (!i_item.instr_word[20] &&
                 (n_addr == wlsu_pkg::GPIO_CLR || n_addr == wlsu_pkg::GPIO_SET))
            n_kind = wlsu_pkg::ST_PIN;
        else if ({2'b00, n_acc} + 34'd3 >= LIMIT)
            n_kind = wlsu_pkg::ST_OOB;
        else
            n_kind = i_item.instr_word[20] ? wlsu_pkg::ST_LOAD : wlsu_pkg::ST_STORE;
    end

    // decode cycle: latch and read both words; finish: merge and write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_addr <= n_addr;
            r_sd   <= i_item.store_data;
            r_lane <= n_acc[1:0];
            r_pre  <= i_item.instr_word[24];
            r_load <= i_item.instr_word[20];
            r_kind <= n_kind;
            r_w0   <= n_w0;
            r_w1   <= n_w1;
            r_two  <= n_acc[1:0] != 2'd0;
            r_d0   <= r_mem[n_w0];
            r_d1   <= r_mem[n_w1];
        end
    end

    logic [63:0] w_pair, w_merge, w_mask;
    logic [5:0]  w_sh;
    always_comb begin
        w_sh    = {r_lane, 3'b000};
        w_pair  = {r_d1, r_d0};
        w_mask  = 64'hFFFF_FFFF << w_sh;
        w_merge = (w_pair & ~w_mask) | ({32'd0, r_sd} << w_sh);
    end

    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            r_mem[i_clr_addr] <= 32'd0;
        end else if (i_cmd.finish && r_kind == wlsu_pkg::ST_STORE) begin
            r_mem[r_w0] <= w_merge[31:0];
            if (r_two) r_mem[r_w1] <= w_merge[63:32];
        end
    end

    logic [63:0] w_ld;
    always_comb begin
        w_ld = w_pair >> w_sh;
        o_result = '0;
        o_result.status = r_kind;
        case (r_kind)
            wlsu_pkg::ST_GSEL: begin
                o_result.dest_write = 1'b1;
                o_result.dest_value = r_addr;
                o_result.eff_address = r_addr;
            end
            wlsu_pkg::ST_LOAD, wlsu_pkg::ST_STORE: begin
                o_result.dest_write = r_load;
                o_result.dest_value = r_load ? w_ld[31:0] : 32'd0;
                o_result.base_write = !r_pre;
                o_result.new_base = r_pre ? 32'd0 : r_addr;
                o_result.eff_address = r_addr;
            end
            wlsu_pkg::ST_PIN, wlsu_pkg::ST_OOB: o_result.eff_address = r_addr;
            default: o_result = '0;
        endcase
        o_status.kind = r_kind;
        o_status.two_words = r_two;
    end
endmodule

[rtl/core/wlsu_ctrl.sv]
// ----------------------------------------------------------------------------
// wlsu_ctrl
// Sequencer: memory clear after reset, then decode / finish per item.
// ----------------------------------------------------------------------------
`include "word_load_store_unit_defines.svh"
module wlsu_ctrl #(
    parameter int unsigned MEM_WORDS = wlsu_pkg::MEM_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  wlsu_pkg::t_dp_status i_status,
    output wlsu_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_done,
    output logic                 o_clr_en,
    output logic [$clog2(MEM_WORDS)-1:0] o_clr_addr
);
    localparam int unsigned AW = $clog2(MEM_WORDS);
    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FINISH} t_state;
    t_state r_state;
    logic [AW-1:0] r_clr;
    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_start) r_state <= S_FINISH;
                S_FINISH: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = r_state != S_IDLE;
    assign o_cmd.decode = r_state == S_IDLE && i_start;
    assign o_cmd.finish = r_state == S_FINISH;
    assign o_clr_en     = r_state == S_CLEAR;
    assign o_clr_addr   = r_clr;
    assign o_done       = o_cmd.finish;

    `WLS_ASSERT_NEXT(a_dec_fin, i_clk, i_rst_n, o_cmd.decode, o_cmd.finish)
    `WLS_ASSERT_IMPL(a_no_clr_fin, i_clk, i_rst_n, o_cmd.finish, !o_clr_en)
    `WLS_ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, o_cmd.finish, !o_busy && r_done)
    `WLS_ASSERT_IMPL(a_kind_rng, i_clk, i_rst_n, o_cmd.finish, i_status.kind <= 3'd5)
endmodule

[rtl/core/word_load_store_unit.sv]
// ----------------------------------------------------------------------------
// word_load_store_unit
// Single-data-transfer unit: condition, shifted offset, indexed word access.
// ----------------------------------------------------------------------------
//  channel  | signals                  | direction
//  command  | start, busy, i_item      | in
//  result   | o_valid, o_result        | out, one cycle, no stall
//
// Each item has a decode cycle that reads both memory words
// through the two read ports, then a finish cycle that reports and writes.
// After reset a clearing pass zeroes the memory one word at a time; busy
// stays high during it. Results cannot be stalled.
module word_load_store_unit #(
    parameter int unsigned MEM_WORDS = wlsu_pkg::MEM_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  wlsu_pkg::t_in_item  i_item,
    output logic                o_valid,
    output wlsu_pkg::t_out_item o_result
);
    wlsu_pkg::t_dp_cmd    w_cmd;
    wlsu_pkg::t_dp_status w_st;
    logic                 w_clr_en;
    logic [$clog2(MEM_WORDS)-1:0] w_clr_addr;

    wlsu_ctrl #(.MEM_WORDS(MEM_WORDS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_status(w_st),
        .o_cmd(w_cmd), .o_busy(busy), .o_done(o_valid),
        .o_clr_en(w_clr_en), .o_clr_addr(w_clr_addr));

    wlsu_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .i_clk(i_clk), .i_item(i_item), .i_cmd(w_cmd), .i_clr_en(w_clr_en),
        .i_clr_addr(w_clr_addr), .o_status(w_st), .o_result(o_result));
endmodule

[tb/word_load_store_unit_test.sv]
// ----------------------------------------------------------------------------
// word_load_store_unit_test
// Drives transfer instructions into the load/store unit and checks every
// result against a behavioral predictor that keeps its own copy of memory.
// ----------------------------------------------------------------------------
module word_load_store_unit_test;

    localparam int unsigned MEM_WORDS = wlsu_pkg::MEM_WORDS_DEF;
    localparam int unsigned WDOG_LIMIT = 4 * MEM_WORDS + 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    wlsu_pkg::t_in_item  i_item;
    logic                o_valid;
    wlsu_pkg::t_out_item o_result;

    word_load_store_unit #(.MEM_WORDS(MEM_WORDS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    wlsu_pkg::t_in_item  pending_items[$];
    wlsu_pkg::t_out_item expected_results[$];
    logic [31:0] mem_image[MEM_WORDS];
    int          send_idle_pct;
    int          fail_count;
    int          idle_cycles;

    function automatic logic flags_allow(logic [3:0] c, logic [3:0] f);
        case (c)
            4'd0:  return f[2];
            4'd1:  return !f[2];
            4'd2:  return f[1];
            4'd3:  return !f[1];
            4'd4:  return f[3];
            4'd5:  return !f[3];
            4'd6:  return f[0];
            4'd7:  return !f[0];
            4'd8:  return f[1] && !f[2];
            4'd9:  return !f[1] || f[2];
            4'd10: return f[3] == f[0];
            4'd11: return f[3] != f[0];
            4'd12: return !f[2] && (f[3] == f[0]);
            4'd13: return f[2] || (f[3] != f[0]);
            4'd14: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] shifted_offset(logic [31:0] x, logic [1:0] kind,
                                                   logic [7:0] amt);
        logic [4:0] r;
        if (amt == 8'd0) return x;
        case (kind)
            wlsu_pkg::SH_LSL: return (amt >= 8'd32) ? 32'd0 : x << amt;
            wlsu_pkg::SH_LSR: return (amt >= 8'd32) ? 32'd0 : x >> amt;
            wlsu_pkg::SH_ASR: begin
                if (amt >= 8'd32) return {32{x[31]}};
                return x[31] ? ~((~x) >> amt) : x >> amt;
            end
            default: begin
                r = amt[4:0];
                if (r == 5'd0) return x;
                return (x >> r) | (x << (6'd32 - r));
            end
        endcase
    endfunction

    // Updates mem_image for stores.
    function automatic wlsu_pkg::t_out_item transfer_outcome(wlsu_pkg::t_in_item it);
        wlsu_pkg::t_out_item res;
        logic [31:0] ins, off, addr, acc, ab, w;
        logic [7:0]  amt;
        int          wi;
        res = '0;
        ins = it.instr_word;
        if (!flags_allow(ins[31:28], it.cond_flags)) return res;
        if (ins[25]) begin
            amt = ins[4] ? it.amount_reg_value[7:0] : {3'b0, ins[11:7]};
            off = shifted_offset(it.offset_reg_value, ins[6:5], amt);
        end else begin
            off = {20'd0, ins[11:0]};
        end
        addr = ins[23] ? it.base_value + off : it.base_value - off;
        res.eff_address = addr;
        if (addr == wlsu_pkg::GPIO_SEL0 || addr == wlsu_pkg::GPIO_SEL1 ||
            addr == wlsu_pkg::GPIO_SEL2) begin
            res.status = wlsu_pkg::ST_GSEL;
            res.dest_write = 1'b1;
            res.dest_value = addr;
            return res;
        end
        if (!ins[20] && (addr == wlsu_pkg::GPIO_CLR || addr == wlsu_pkg::GPIO_SET)) begin
            res.status = wlsu_pkg::ST_PIN;
            return res;
        end
        acc = ins[24] ? addr : it.base_value;
        if ({32'd0, acc} + 64'd3 >= 64'(MEM_WORDS) * 4) begin
            res.status = wlsu_pkg::ST_OOB;
            return res;
        end
        w = 0;
        for (int k = 0; k < 4; k++) begin
            ab = acc + k;
            wi = int'(ab >> 2);
            if (ins[20])
                w |= ((mem_image[wi] >> (8 * ab[1:0])) & 32'hFF) << (8 * k);
            else
                mem_image[wi][8*ab[1:0] +: 8] = it.store_data[8*k +: 8];
        end
        if (ins[20]) begin
            res.status = wlsu_pkg::ST_LOAD;
            res.dest_write = 1'b1;
            res.dest_value = w;
        end else begin
            res.status = wlsu_pkg::ST_STORE;
        end
        if (!ins[24]) begin
            res.base_write = 1'b1;
            res.new_base = addr;
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Random instruction: mostly in-range accesses so loads see stored data.
    function automatic wlsu_pkg::t_in_item rand_transfer();
        wlsu_pkg::t_in_item it;
        int       pick;
        it.instr_word = $urandom();
        it.cond_flags = 4'($urandom());
        it.offset_reg_value = rand_word();
        it.amount_reg_value = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 40);
        it.store_data = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            it.instr_word[31:28] = $urandom_range(0, 3) == 0 ? 4'($urandom()) : 4'd14;
            it.base_value = $urandom_range(0, 255);
            if (it.instr_word[25]) it.offset_reg_value = $urandom_range(0, 63);
            else it.instr_word[11:0] = 12'($urandom_range(0, 255));
            it.instr_word[23] = 1'b1;
        end else if (pick < 70) begin
            it.instr_word[31:28] = 4'd14;
            it.instr_word[25] = 1'b0;
            it.instr_word[11:0] = 12'd0;
            case ($urandom_range(0, 4))
                0: it.base_value = wlsu_pkg::GPIO_SEL0;
                1: it.base_value = wlsu_pkg::GPIO_SEL1;
                2: it.base_value = wlsu_pkg::GPIO_SEL2;
                3: it.base_value = wlsu_pkg::GPIO_CLR;
                default: it.base_value = wlsu_pkg::GPIO_SET;
            endcase
        end else if (pick < 80) begin
            it.instr_word[31:28] = 4'd14;
            it.base_value = 4 * MEM_WORDS - $urandom_range(1, 8);
        end else begin
            it.base_value = rand_word();
        end
        return it;
    endfunction

    function automatic wlsu_pkg::t_in_item directed_transfer(logic [3:0] cnd, logic i,
                                                   logic p, logic u,
                                                   logic ld, logic [11:0] off, logic [31:0] base,
                                                   logic [31:0] rm, logic [31:0] rs,
                                                   logic [31:0] sd, logic [3:0] flg);
        wlsu_pkg::t_in_item it;
        it.instr_word = {cnd, 2'b01, i, p, u, 2'b00, ld, 4'd1, 4'd2, off};
        it.cond_flags = flg;
        it.base_value = base;
        it.offset_reg_value = rm;
        it.amount_reg_value = rs;
        it.store_data = sd;
        return it;
    endfunction

    task automatic queue_directed();
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 0, 12'h003, 32'd0, 0, 0,
                                                  32'hDEAD_BEEF, 4'd0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 1, 12'h003, 32'd0, 0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 0, 0, 1, 12'hFFF, 32'd0, 0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd15, 0, 1, 1, 0, 12'h0, 32'd0, 0, 0, 1, 4'hF));
        pending_items.push_back(directed_transfer(4'd0, 0, 1, 1, 1, 12'h4, 32'd0, 0, 0, 0, 4'h4));
        pending_items.push_back(directed_transfer(4'd0, 0, 1, 1, 1, 12'h4, 32'd0, 0, 0, 0, 4'h0));
        // immediate shift amount zero, every shift type
        for (int t = 0; t < 4; t++)
            pending_items.push_back(directed_transfer(4'd14, 1, 1, 1, 1, 12'(t << 5), 32'd8,
                                                      32'd4, 0, 0, 0));
        // register shifts by 0, 32, 33, 40, 64
        pending_items.push_back(directed_transfer(4'd14, 1, 1, 1, 1, 12'h050, 32'd8,
                                                  32'hFFFF_FFFC, 32'd32, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 1, 1, 0, 1, 12'h050, 32'd8,
                                                  32'h8000_0000, 32'd40, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 1, 1, 1, 1, 12'h030, 32'd8,
                                                  32'h8000_0000, 32'd33, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 1, 1, 1, 1, 12'h070, 32'd8,
                                                  32'h10, 32'd64, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 1, 0, 1, 0, 12'h010, 32'd16,
                                                  32'h4, 32'hFFFF_FF00, 32'h1234_5678, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 1, 12'h0, wlsu_pkg::GPIO_SEL0,
                                                  0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 0, 12'h4, wlsu_pkg::GPIO_SEL0,
                                                  0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 0, 0, 12'h8,
                                                  wlsu_pkg::GPIO_SEL2 + 8, 0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 0, 12'h0, wlsu_pkg::GPIO_SET,
                                                  0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 0, 12'h0, wlsu_pkg::GPIO_CLR,
                                                  0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 1, 12'h0, wlsu_pkg::GPIO_CLR,
                                                  0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 0, 12'h0, 4 * MEM_WORDS - 4,
                                                  0, 0, 32'hA5A5_5A5A, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 1, 1, 12'h1, 4 * MEM_WORDS - 4,
                                                  0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 1, 0, 1, 12'h1, 32'd0, 0, 0, 0, 0));
        pending_items.push_back(directed_transfer(4'd14, 0, 0, 1, 0, 12'h1, 32'hFFFF_FFFF, 0, 0,
                                                  0, 0));
    endtask

    // Driver: holds start high until the item is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_results.push_back(transfer_outcome(i_item));
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_item <= pending_items.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_items.size() > 0
                     && $urandom_range(0, 99) >= send_idle_pct) begin
            i_item <= pending_items.pop_front();
            start <= 1'b1;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                wlsu_pkg::t_out_item e;
                e = expected_results.pop_front();
                if (o_result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_result.status); fail_count++;
                end
                if (o_result.dest_write !== e.dest_write) begin
                    $error("dest_write exp %0d got %0d", e.dest_write, o_result.dest_write);
                    fail_count++;
                end
                if (o_result.dest_value !== e.dest_value) begin
                    $error("dest_value exp %h got %h", e.dest_value, o_result.dest_value);
                    fail_count++;
                end
                if (o_result.base_write !== e.base_write) begin
                    $error("base_write exp %0d got %0d", e.base_write, o_result.base_write);
                    fail_count++;
                end
                if (o_result.new_base !== e.new_base) begin
                    $error("new_base exp %h got %h", e.new_base, o_result.new_base);
                    fail_count++;
                end
                if (o_result.eff_address !== e.eff_address) begin
                    $error("eff_address exp %h got %h", e.eff_address, o_result.eff_address);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles without an accepted item or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 15;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++) mem_image[i] = 32'd0;
        queue_directed();
        for (int i = 0; i < 350; i++) pending_items.push_back(rand_transfer());
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        send_idle_pct = 45;
        for (int i = 0; i < 350; i++) pending_items.push_back(rand_transfer());
        wait (pending_items.size() == 0);
        send_idle_pct = 0;
        for (int i = 0; i < 350; i++) pending_items.push_back(rand_transfer());
        wait (pending_items.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
